>>> rtl/core/silhouette_edge_set_assert.svh
// Assertion macros for the silhouette edge set.
`ifndef SILHOUETTE_EDGE_SET_ASSERT_SVH
`define SILHOUETTE_EDGE_SET_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SES_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("silhouette_edge_set: check failed");
// Next-cycle implication.
`define SES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("silhouette_edge_set: check failed");
`endif

>>> rtl/core/ses_pkg.sv
`timescale 1ns / 1ps
package ses_pkg;
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_FACE  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_LIGHT_X = 2'd0,
		REG_LIGHT_Y = 2'd1,
		REG_LIGHT_Z = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VRD0,
		ST_VRD1,
		ST_VRD2,
		ST_VWAIT,
		ST_DIFF,
		ST_CROSS,
		ST_NSUM,
		ST_DOT,
		ST_DSUM,
		ST_DECIDE,
		ST_SRCH,
		ST_SCMP,
		ST_LRD,
		ST_LWAIT,
		ST_MOVE,
		ST_APPEND,
		ST_NEXT,
		ST_RRD,
		ST_RWAIT,
		ST_OUT
	} state_t;

	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;
	localparam int REG_W  = 16;
endpackage

>>> rtl/core/silhouette_edge_set.sv
`timescale 1ns / 1ps
// Silhouette edge set: vertex store plus an undirected edge set for shadow volumes.
// Input channel (valid/stall): operation, index_a/b/c, pos_x/y/z. Output channel
// (valid/stall): edge_total, edge_start, edge_end, edge_valid, overflow, one
// result transfer per input transfer.
// Load vertex writes one vertex memory entry. Add face reads its three corners,
// forms n = (v2-v1)x(v1-v0) and the dot with (v0+v1+v2-3*light), one multiply per
// cycle. A positive dot toggles edges (a,b), (b,c), (c,a): each toggle scans the
// edge memory one entry per read; a match is removed by moving the last entry
// into its slot, otherwise the edge is appended (or overflow is set when full).
// Read edge returns one slot; clear set zeroes the count.
// Load and clear go straight to the result; read passes ST_RRD and ST_RWAIT.
// A face that toggles edges adds, per edge, a scan of the table entry by entry
// plus an append or a removal; the sequential edge memory scan sets the worst
// case, which grows with EDGE_DEPTH.
// One item is in work at a time; the next input transfer is taken the cycle
// after the result transfer. When the receiver stalls, the result holds.
// Reset clears the count, overflow, lights and control; memories are undefined.
module silhouette_edge_set #(
	parameter int VERTEX_DEPTH = 4096,
	parameter int EDGE_DEPTH   = 4096,
	parameter int COORD_WIDTH  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] operation,
	input  logic [ses_pkg::IDX_W-1:0] index_a,
	input  logic [ses_pkg::IDX_W-1:0] index_b,
	input  logic [ses_pkg::IDX_W-1:0] index_c,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	output logic out_valid,
	input  logic out_stall,
	output logic [ses_pkg::CNT_W-1:0] edge_total,
	output logic [ses_pkg::IDX_W-1:0] edge_start,
	output logic [ses_pkg::IDX_W-1:0] edge_end,
	output logic edge_valid,
	output logic overflow
);
	localparam int VA_W = $clog2(VERTEX_DEPTH);
	localparam int EA_W = $clog2(EDGE_DEPTH);
	localparam int EC_W = EA_W + 1;
	localparam int VW   = 3 * COORD_WIDTH;
	localparam int AW   = COORD_WIDTH + 1;  // corner differences
	localparam int PW   = 2 * AW;           // cross products
	localparam int NW   = PW + 1;           // normal components
	localparam int SW   = COORD_WIDTH + 3;  // corner sum minus 3*light
	localparam int QW   = NW + SW;          // dot terms
	localparam int DW   = QW + 2;           // dot sum
	localparam int IW   = ses_pkg::IDX_W;

	// memories
	logic [VW-1:0] vmem [VERTEX_DEPTH];
	logic [2*IW-1:0] emem [EDGE_DEPTH];
	logic [VW-1:0] vrd_q;
	logic [2*IW-1:0] erd_q;

	ses_pkg::state_t state_q, state_d;
	logic [IW-1:0] ia_q, ib_q, ic_q;
	logic [EC_W-1:0] cnt_q;
	logic ovf_q;
	logic [COORD_WIDTH-1:0] light_q [3];
	logic signed [COORD_WIDTH-1:0] v_q [3][3];
	logic signed [AW-1:0] a_q [3], b_q [3];
	logic signed [SW-1:0] s_q [3];
	logic signed [PW-1:0] p_q [6];
	logic signed [NW-1:0] n_q [3];
	logic signed [QW-1:0] q_q [3];
	logic signed [DW-1:0] dot_q;
	logic [2:0] step_q;
	logic [1:0] edge_n_q;
	logic [EC_W-1:0] scan_q, hit_q;
	logic [IW-1:0] ea, eb;
	logic res_full_q;
	logic [IW-1:0] rs_q, re_q;
	logic rv_q;

	logic v_re, v_we, e_re, e_we;
	logic [VA_W-1:0] v_ra, v_wa;
	logic [EA_W-1:0] e_ra, e_wa;
	logic [VW-1:0] v_wd;
	logic [2*IW-1:0] e_wd;

	always_ff @(posedge clk) begin
		if (v_we) vmem[v_wa] <= v_wd;
		if (v_re) vrd_q <= vmem[v_ra];
	end
	always_ff @(posedge clk) begin
		if (e_we) emem[e_wa] <= e_wd;
		if (e_re) erd_q <= emem[e_ra];
	end

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != ses_pkg::ST_IDLE) || res_full_q;
	assign out_valid = res_full_q;
	assign edge_total = ses_pkg::CNT_W'(cnt_q);
	assign edge_start = rs_q;
	assign edge_end = re_q;
	assign edge_valid = rv_q;
	assign overflow = ovf_q;

	// current edge endpoints
	always_comb begin
		case (edge_n_q)
			2'd0: begin ea = ia_q; eb = ib_q; end
			2'd1: begin ea = ib_q; eb = ic_q; end
			default: begin ea = ic_q; eb = ia_q; end
		endcase
	end

	logic in_vrange_c, corner_ok;
	logic [IW-1:0] corner;
	always_comb begin
		case (step_q[1:0])
			2'd0: corner = ia_q;
			2'd1: corner = ib_q;
			default: corner = ic_q;
		endcase
		corner_ok = 32'(corner) < VERTEX_DEPTH;
		in_vrange_c = 32'(index_a) < VERTEX_DEPTH;
	end

	logic match_c;
	assign match_c = (erd_q[2*IW-1:IW] == ea && erd_q[IW-1:0] == eb)
		|| (erd_q[2*IW-1:IW] == eb && erd_q[IW-1:0] == ea);

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		v_re = 1'b0; v_we = 1'b0; e_re = 1'b0; e_we = 1'b0;
		v_ra = VA_W'(corner); v_wa = VA_W'(index_a);
		v_wd = {pos_z, pos_y, pos_x};
		e_ra = EA_W'(scan_q); e_wa = EA_W'(hit_q); e_wd = erd_q;
		unique case (state_q)
			ses_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (ses_pkg::op_t'(operation))
						ses_pkg::OP_LOAD: begin
							v_we = in_vrange_c;
							state_d = ses_pkg::ST_OUT;
						end
						ses_pkg::OP_FACE: state_d = ses_pkg::ST_VRD0;
						ses_pkg::OP_READ: state_d = ses_pkg::ST_RRD;
						ses_pkg::OP_CLEAR: state_d = ses_pkg::ST_OUT;
						default: state_d = ses_pkg::ST_OUT;
					endcase
				end
			end
			ses_pkg::ST_VRD0, ses_pkg::ST_VRD1, ses_pkg::ST_VRD2: begin
				v_re = corner_ok;
				state_d = ses_pkg::state_t'(state_q + 5'd1);
			end
			ses_pkg::ST_VWAIT: state_d = ses_pkg::ST_DIFF;
			ses_pkg::ST_DIFF: state_d = ses_pkg::ST_CROSS;
			ses_pkg::ST_CROSS: if (step_q == 3'd5) state_d = ses_pkg::ST_NSUM;
			ses_pkg::ST_NSUM: state_d = ses_pkg::ST_DOT;
			ses_pkg::ST_DOT: if (step_q == 3'd2) state_d = ses_pkg::ST_DSUM;
			ses_pkg::ST_DSUM: state_d = ses_pkg::ST_DECIDE;
			ses_pkg::ST_DECIDE:
				state_d = (!dot_q[DW-1] && dot_q != '0) ? ses_pkg::ST_SRCH
					: ses_pkg::ST_OUT;
			ses_pkg::ST_SRCH: begin
				if (scan_q < cnt_q && 32'(scan_q) < EDGE_DEPTH) begin
					e_re = 1'b1;
					state_d = ses_pkg::ST_SCMP;
				end else begin
					state_d = ses_pkg::ST_APPEND;
				end
			end
			ses_pkg::ST_SCMP: state_d = match_c ? ses_pkg::ST_LRD : ses_pkg::ST_SRCH;
			ses_pkg::ST_LRD: begin
				e_re = 1'b1;
				e_ra = EA_W'(cnt_q - EC_W'(1));
				state_d = ses_pkg::ST_LWAIT;
			end
			ses_pkg::ST_LWAIT: state_d = ses_pkg::ST_MOVE;
			ses_pkg::ST_MOVE: begin
				e_we = 1'b1;
				state_d = ses_pkg::ST_NEXT;
			end
			ses_pkg::ST_APPEND: begin
				e_we = 32'(cnt_q) < EDGE_DEPTH;
				e_wa = EA_W'(cnt_q);
				e_wd = {ea, eb};
				state_d = ses_pkg::ST_NEXT;
			end
			ses_pkg::ST_NEXT:
				state_d = (edge_n_q == 2'd2) ? ses_pkg::ST_OUT : ses_pkg::ST_SRCH;
			ses_pkg::ST_RRD: begin
				e_re = 1'b1;
				e_ra = EA_W'(ia_q);
				state_d = ses_pkg::ST_RWAIT;
			end
			ses_pkg::ST_RWAIT: state_d = ses_pkg::ST_OUT;
			ses_pkg::ST_OUT: if (!res_full_q || out_acc) state_d = ses_pkg::ST_IDLE;
			default: state_d = ses_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ses_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			res_full_q <= 1'b0;
			for (int i = 0; i < 3; i++) light_q[i] <= '0;
			step_q <= '0;
			edge_n_q <= '0;
			scan_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ses_pkg::REG_LIGHT_X: light_q[0] <= cfg_data;
					ses_pkg::REG_LIGHT_Y: light_q[1] <= cfg_data;
					ses_pkg::REG_LIGHT_Z: light_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (out_acc) res_full_q <= 1'b0;
			if (state_q == ses_pkg::ST_OUT && (!res_full_q || out_acc))
				res_full_q <= 1'b1;
			if (in_acc) begin
				step_q <= '0;
				if (ses_pkg::op_t'(operation) == ses_pkg::OP_CLEAR) cnt_q <= '0;
			end
			unique case (state_q)
				ses_pkg::ST_VRD0, ses_pkg::ST_VRD1, ses_pkg::ST_VRD2:
					step_q <= step_q + 3'd1;
				ses_pkg::ST_VWAIT, ses_pkg::ST_DIFF, ses_pkg::ST_NSUM: step_q <= '0;
				ses_pkg::ST_CROSS, ses_pkg::ST_DOT: step_q <= step_q + 3'd1;
				ses_pkg::ST_DECIDE: begin
					edge_n_q <= '0;
					scan_q <= '0;
				end
				ses_pkg::ST_SCMP: if (!match_c) scan_q <= scan_q + EC_W'(1);
				ses_pkg::ST_MOVE: cnt_q <= cnt_q - EC_W'(1);
				ses_pkg::ST_APPEND: begin
					if (32'(cnt_q) < EDGE_DEPTH) cnt_q <= cnt_q + EC_W'(1);
					else ovf_q <= 1'b1;
				end
				ses_pkg::ST_NEXT: begin
					edge_n_q <= edge_n_q + 2'd1;
					scan_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	logic [2:0] vslot_q;
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ia_q <= index_a; ib_q <= index_b; ic_q <= index_c;
			rv_q <= 1'b0; rs_q <= '0; re_q <= '0;
		end
		vslot_q <= {corner_ok, step_q[1:0]};
		// capture each vertex in the cycle after its read
		if (state_q == ses_pkg::ST_VRD1 || state_q == ses_pkg::ST_VRD2
			|| state_q == ses_pkg::ST_VWAIT) begin
			for (int k = 0; k < 3; k++)
				v_q[vslot_q[1:0]][k] <= vslot_q[2]
					? $signed(vrd_q[k*COORD_WIDTH +: COORD_WIDTH]) : '0;
		end
		unique case (state_q)
			ses_pkg::ST_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					a_q[k] <= AW'(v_q[2][k]) - AW'(v_q[1][k]);
					b_q[k] <= AW'(v_q[1][k]) - AW'(v_q[0][k]);
					// 3*light as shift plus add
					s_q[k] <= SW'(v_q[0][k]) + SW'(v_q[1][k]) + SW'(v_q[2][k])
						- (SW'($signed(light_q[k])) <<< 1) - SW'($signed(light_q[k]));
				end
			end
			ses_pkg::ST_CROSS: begin
				// one product per cycle
				case (step_q)
					3'd0: p_q[0] <= PW'(a_q[1]) * PW'(b_q[2]);
					3'd1: p_q[1] <= PW'(a_q[2]) * PW'(b_q[1]);
					3'd2: p_q[2] <= PW'(a_q[2]) * PW'(b_q[0]);
					3'd3: p_q[3] <= PW'(a_q[0]) * PW'(b_q[2]);
					3'd4: p_q[4] <= PW'(a_q[0]) * PW'(b_q[1]);
					default: p_q[5] <= PW'(a_q[1]) * PW'(b_q[0]);
				endcase
			end
			ses_pkg::ST_NSUM: begin
				n_q[0] <= NW'(p_q[0]) - NW'(p_q[1]);
				n_q[1] <= NW'(p_q[2]) - NW'(p_q[3]);
				n_q[2] <= NW'(p_q[4]) - NW'(p_q[5]);
			end
			ses_pkg::ST_DOT: begin
				case (step_q[1:0])
					2'd0: q_q[0] <= QW'(n_q[0]) * QW'(s_q[0]);
					2'd1: q_q[1] <= QW'(n_q[1]) * QW'(s_q[1]);
					default: q_q[2] <= QW'(n_q[2]) * QW'(s_q[2]);
				endcase
			end
			ses_pkg::ST_DSUM: dot_q <= DW'(q_q[0]) + DW'(q_q[1]) + DW'(q_q[2]);
			ses_pkg::ST_RWAIT: begin
				if (EC_W'(ia_q) < cnt_q && 32'(ia_q) < EDGE_DEPTH) begin
					rv_q <= 1'b1;
					rs_q <= erd_q[2*IW-1:IW];
					re_q <= erd_q[IW-1:0];
				end
			end
			default: ;
		endcase
		if (state_q == ses_pkg::ST_SCMP) hit_q <= scan_q;
	end

	`include "silhouette_edge_set_assert.svh"

	`SES_ASSERT_IMPL(a_no_accept_busy, state_q != ses_pkg::ST_IDLE, !in_acc)
	`SES_ASSERT_IMPL(a_cnt_bound, 1'b1, 32'(cnt_q) <= EDGE_DEPTH)
	`SES_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q)
	`SES_ASSERT_IMPL(a_move_nonempty, state_q == ses_pkg::ST_MOVE, cnt_q != '0)
endmodule

>>> tb/tb_silhouette_edge_set.sv
`timescale 1ns / 1ps
// Scoreboard: keeps its own copy of the vertex store, edge set and lights,
// and queues the expected result for every input transfer.
class edge_set_scoreboard;
	logic signed [15:0] light [3];
	logic signed [15:0] vert [4096][3];
	logic [11:0] tab_s [4096];
	logic [11:0] tab_e [4096];
	int unsigned count;
	bit ovf;
	logic [38:0] pending [$]; // {total, start, end, valid, ovf}
	int errors;
	int faces_lit, reads_hit;

	function new();
		count = 0;
		ovf = 0;
		errors = 0;
		faces_lit = 0;
		reads_hit = 0;
		for (int k = 0; k < 3; k++) light[k] = 0;
	endfunction

	function void set_light(int k, logic [15:0] v);
		light[k] = v;
	endfunction

	function void toggle(logic [11:0] a, logic [11:0] b);
		for (int i = 0; i < count; i++) begin
			if ((tab_s[i] == a && tab_e[i] == b) || (tab_s[i] == b && tab_e[i] == a)) begin
				tab_s[i] = tab_s[count-1];
				tab_e[i] = tab_e[count-1];
				count--;
				return;
			end
		end
		if (count >= 4096) begin
			ovf = 1;
			return;
		end
		tab_s[count] = a;
		tab_e[count] = b;
		count++;
	endfunction

	// Sign of n . (v0+v1+v2-3*light), exact in 64 bits for 16-bit coordinates.
	function void face(logic [11:0] i0, logic [11:0] i1, logic [11:0] i2);
		longint v0 [3], v1 [3], v2 [3], a [3], b [3], n [3];
		longint dot;
		dot = 0;
		for (int k = 0; k < 3; k++) begin
			v0[k] = vert[i0][k];
			v1[k] = vert[i1][k];
			v2[k] = vert[i2][k];
			a[k] = v2[k] - v1[k];
			b[k] = v1[k] - v0[k];
		end
		n[0] = a[1]*b[2] - a[2]*b[1];
		n[1] = a[2]*b[0] - a[0]*b[2];
		n[2] = a[0]*b[1] - a[1]*b[0];
		for (int k = 0; k < 3; k++)
			dot += n[k] * (v0[k] + v1[k] + v2[k] - 3 * longint'(light[k]));
		if (dot > 0) begin
			faces_lit++;
			toggle(i0, i1);
			toggle(i1, i2);
			toggle(i2, i0);
		end
	endfunction

	function void note_input(ses_pkg::op_t op, logic [11:0] ia, logic [11:0] ib,
			logic [11:0] ic, logic [15:0] px, logic [15:0] py, logic [15:0] pz);
		logic [11:0] s, e;
		bit v;
		s = 0;
		e = 0;
		v = 0;
		case (op)
			ses_pkg::OP_LOAD: begin
				vert[ia][0] = px;
				vert[ia][1] = py;
				vert[ia][2] = pz;
			end
			ses_pkg::OP_FACE: face(ia, ib, ic);
			ses_pkg::OP_READ: begin
				if (ia < count) begin
					s = tab_s[ia];
					e = tab_e[ia];
					v = 1;
					reads_hit++;
				end
			end
			default: count = 0;
		endcase
		pending.push_back({13'(count), s, e, v, ovf});
	endfunction

	function void check_result(logic [12:0] total, logic [11:0] s, logic [11:0] e,
			logic v, logic o);
		logic [38:0] x;
		if (pending.size() == 0) begin
			$error("result transfer with nothing expected");
			errors++;
			return;
		end
		x = pending.pop_front();
		if (total !== x[38:26]) begin
			$error("edge_total expected %0d got %0d", x[38:26], total); errors++;
		end
		if (s !== x[25:14]) begin
			$error("edge_start expected %0d got %0d", x[25:14], s); errors++;
		end
		if (e !== x[13:2]) begin
			$error("edge_end expected %0d got %0d", x[13:2], e); errors++;
		end
		if (v !== x[1]) begin
			$error("edge_valid expected %0d got %0d", x[1], v); errors++;
		end
		if (o !== x[0]) begin
			$error("overflow expected %0d got %0d", x[0], o); errors++;
		end
	endfunction
endclass

module tb_silhouette_edge_set;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [ses_pkg::REG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] operation;
	logic [ses_pkg::IDX_W-1:0] index_a, index_b, index_c;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic out_valid;
	logic out_stall;
	logic [ses_pkg::CNT_W-1:0] edge_total;
	logic [ses_pkg::IDX_W-1:0] edge_start, edge_end;
	logic edge_valid;
	logic overflow;

	edge_set_scoreboard sb;
	longint cycles;

	// Which vertices have been loaded; faces only use these.
	int loaded [$];

	silhouette_edge_set dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Run limit: far above the worst face scans and stalls of this run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd20_000_000) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [11:0] r12();
		return 12'($urandom);
	endfunction

	function automatic logic [15:0] r16();
		return 16'($urandom);
	endfunction

	// Receiver: raises stall for a random time, or not at all, before taking each result.
	initial begin
		int gap;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17));
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Output monitor: a transfer is valid high and stall low at the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(edge_total, edge_start, edge_end, edge_valid, overflow);
	end

	task automatic write_light(ses_pkg::reg_idx_t r, logic [15:0] v);
		cfg_we <= 1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_light(int'(r), v);
		@(posedge clk);
	endtask

	// One input transfer, with a random gap first unless told not to wait.
	task automatic send(ses_pkg::op_t op, logic [11:0] ia, logic [11:0] ib,
			logic [11:0] ic, logic [15:0] px, logic [15:0] py, logic [15:0] pz,
			bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 17)));
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		operation <= op;
		index_a <= ia;
		index_b <= ib;
		index_c <= ic;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, ia, ib, ic, px, py, pz);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load(logic [11:0] ia, logic [15:0] px, logic [15:0] py, logic [15:0] pz);
		send(ses_pkg::OP_LOAD, ia, r12(), r12(), px, py, pz);
		loaded.push_back(ia);
	endtask

	function automatic logic [11:0] pick_vertex();
		return 12'(loaded[$urandom_range(0, loaded.size() - 1)]);
	endfunction

	// Random face over loaded vertices; sometimes degenerate.
	task automatic random_face();
		logic [11:0] a, b, c;
		a = pick_vertex();
		b = pick_vertex();
		c = ($urandom_range(0, 9) == 0) ? a : pick_vertex();
		send(ses_pkg::OP_FACE, a, b, c, r16(), r16(), r16());
	endtask

	initial begin
		sb = new();
		cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = ses_pkg::REG_LIGHT_X;
		cfg_data = 0;
		in_valid = 0;
		operation = ses_pkg::OP_LOAD;
		index_a = 0;
		index_b = 0;
		index_c = 0;
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, each operation, degenerate face, read past count.
		write_light(ses_pkg::REG_LIGHT_X, 16'h0000);
		write_light(ses_pkg::REG_LIGHT_Y, 16'h0000);
		write_light(ses_pkg::REG_LIGHT_Z, 16'h8000);
		load(12'd0, 16'h0100, 16'h0000, 16'h0000);
		load(12'd1, 16'h0000, 16'h0100, 16'h0000);
		load(12'd2, 16'h0000, 16'h0000, 16'h0100);
		load(12'd4095, 16'h7FFF, 16'h8000, 16'h7FFF);
		load(12'd2730, 16'h8000, 16'h7FFF, 16'h8000);
		load(12'd1365, 16'hFFFF, 16'h5555, 16'hAAAA);
		send(ses_pkg::OP_FACE, 12'd0, 12'd1, 12'd2, 0, 0, 0);
		send(ses_pkg::OP_FACE, 12'd0, 12'd2, 12'd1, 0, 0, 0);
		send(ses_pkg::OP_FACE, 12'd0, 12'd1, 12'd2, 0, 0, 0);
		send(ses_pkg::OP_FACE, 12'd4095, 12'd2730, 12'd1365, 0, 0, 0);
		send(ses_pkg::OP_FACE, 12'd4095, 12'd1365, 12'd2730, 0, 0, 0);
		send(ses_pkg::OP_FACE, 12'd1, 12'd1, 12'd2, 0, 0, 0);
		send(ses_pkg::OP_READ, 12'd0, 0, 0, 0, 0, 0);
		send(ses_pkg::OP_READ, 12'd2, 0, 0, 0, 0, 0);
		send(ses_pkg::OP_READ, 12'd4095, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(ses_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
		send(ses_pkg::OP_READ, 12'd0, 0, 0, 0, 0, 0);
		// Sender holds off until the block has answered everything.
		drain();

		// Random phases under several light settings, extremes among them.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_light(ses_pkg::REG_LIGHT_X, 16'h7FFF);
					write_light(ses_pkg::REG_LIGHT_Y, 16'h8000);
					write_light(ses_pkg::REG_LIGHT_Z, 16'h7FFF);
				end
				1: begin
					write_light(ses_pkg::REG_LIGHT_X, 16'h8000);
					write_light(ses_pkg::REG_LIGHT_Y, 16'h7FFF);
					write_light(ses_pkg::REG_LIGHT_Z, 16'h8000);
				end
				default: begin
					write_light(ses_pkg::REG_LIGHT_X, r16());
					write_light(ses_pkg::REG_LIGHT_Y, r16());
					write_light(ses_pkg::REG_LIGHT_Z, r16());
				end
			endcase
			for (int n = 0; n < 20; n++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3: load(r12(), r16(), r16(), r16());
					4, 5, 6, 7, 8, 9, 10, 11, 12: random_face();
					13, 14, 15, 16: send(ses_pkg::OP_READ,
						($urandom_range(0, 3) == 0) ? r12() :
						12'($urandom_range(0, sb.count + 1)), r12(), r12(),
						r16(), r16(), r16());
					17, 18: send(ses_pkg::OP_READ, 12'($urandom_range(0, 2)), 0, 0, 0, 0, 0);
					default: if ($urandom_range(0, 3) == 0)
						send(ses_pkg::OP_CLEAR, r12(), r12(), r12(), r16(), r16(), r16());
					else
						random_face();
				endcase
			end
			drain();
		end

		$display("covered %0d faces that toggled edges, %0d reads that hit, overflow %0d",
			sb.faces_lit, sb.reads_hit, sb.ovf);
		$display("light registers written at both extremes and random values");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
